>>> rtl/rmst_pkg.sv
// ----------------------------------------------------------------------------
// rmst_pkg: shared types and constants of the range minimum tree
// Value type, neutral element, controller states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rmst_pkg;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned VAL_W = 61;

  // Operation codes carried in the func field.
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef logic signed [VAL_W-1:0] rmst_val_t;

  // Neutral element of the minimum, held by every node after the clearing sweep that follows reset.
  localparam rmst_val_t NEUTRAL_MIN = 61'sd1000000000000000000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_LEVEL,
    ST_QRY_A,
    ST_QRY_B,
    ST_QRY_DONE
  } rmst_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic upd_start;
    logic upd_level;
    logic qry_start;
    logic qry_a;
    logic qry_b;
    logic out_load;
  } rmst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic in_query;
    logic upd_ok;
    logic upd_last;
    logic qry_more;
    logic out_free;
  } rmst_stat_t;

  function automatic rmst_val_t min_val(input rmst_val_t a, input rmst_val_t b);
    min_val = (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rmst_in_if.sv
// ----------------------------------------------------------------------------
// rmst_in_if: request channel of the range minimum tree
// Valid/ready channel that carries one update or query request per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rmst_in_if
  import rmst_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              func;
  logic [IDX_W-1:0]  left_index;
  logic [IDX_W-1:0]  right_index;
  rmst_val_t         value;

  modport source (output valid, output func, output left_index, output right_index,
                  output value, input ready);
  modport sink   (input valid, input func, input left_index, input right_index,
                  input value, output ready);
endinterface

`default_nettype wire

>>> rtl/rmst_out_if.sv
// ----------------------------------------------------------------------------
// rmst_out_if: result channel of the range minimum tree
// Valid/ready channel that carries one query minimum per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rmst_out_if
  import rmst_pkg::*;
;
  logic      valid;
  logic      ready;
  rmst_val_t minimum;

  modport source (output valid, output minimum, input ready);
  modport sink   (input valid, input minimum, output ready);
endinterface

`default_nettype wire

>>> rtl/rmst_ctrl.sv
// ----------------------------------------------------------------------------
// rmst_ctrl: sequencer of the range minimum tree
// Runs the clearing sweep, the bottom-up update walk and the two-phase
// query walk, and issues one command group to the datapath each cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmst_ctrl
  import rmst_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire rmst_stat_t stat,
  output rmst_cmd_t       cmd
);

  rmst_state_t state_r;
  rmst_state_t state_nxt;
  logic        accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (stat.in_query) begin
            state_nxt = ST_QRY_A;
          end else if (stat.upd_ok) begin
            state_nxt = ST_UPD_LEVEL;
          end
        end
      end
      ST_UPD_LEVEL: begin
        if (stat.upd_last) state_nxt = ST_IDLE;
      end
      ST_QRY_A: begin
        state_nxt = stat.qry_more ? ST_QRY_B : ST_QRY_DONE;
      end
      ST_QRY_B: begin
        state_nxt = ST_QRY_A;
      end
      ST_QRY_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_CLEAR:     cmd.clr_step = 1'b1;
      ST_IDLE: begin
        if (accept) begin
          if (stat.in_query) begin
            cmd.qry_start = 1'b1;
          end else begin
            cmd.upd_start = stat.upd_ok;
          end
        end
      end
      ST_UPD_LEVEL: cmd.upd_level = 1'b1;
      ST_QRY_A:     cmd.qry_a = 1'b1;
      ST_QRY_B:     cmd.qry_b = 1'b1;
      ST_QRY_DONE:  cmd.out_load = stat.out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/rmst_datapath.sv
// ----------------------------------------------------------------------------
// rmst_datapath: node store and arithmetic of the range minimum tree
// Holds the node memory, the update and query walk registers, the running
// minimum and the output register, and reports status to the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmst_datapath
  import rmst_pkg::*;
#(
  parameter int unsigned SIZE = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rmst_cmd_t        cmd,
  output rmst_stat_t            stat,
  input  wire logic             in_func,
  input  wire logic [IDX_W-1:0] in_left_index,
  input  wire logic [IDX_W-1:0] in_right_index,
  input  wire rmst_val_t        in_value,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rmst_val_t             out_minimum
);

  // Node addresses span 0 .. 2*SIZE-1; the query bound reaches 2*SIZE.
  localparam int unsigned AW    = $clog2(2 * SIZE);
  localparam int unsigned BW    = AW + 1;
  localparam int unsigned CW    = (BW > IDX_W + 1) ? BW : IDX_W + 1;
  localparam int unsigned DEPTH = 2 * SIZE;

  rmst_val_t         mem [0:DEPTH-1];
  rmst_val_t         rdata_r;

  logic [AW-1:0]     clr_cnt_r;
  logic [AW-1:0]     node_r;
  rmst_val_t         cur_r;
  logic [BW-1:0]     qa_r;
  logic [BW-1:0]     qb_r;
  rmst_val_t         best_r;
  logic              pa_r;
  logic              pb_r;
  logic              out_valid_r;
  rmst_val_t         out_min_r;

  logic              we;
  logic [AW-1:0]     waddr;
  rmst_val_t         wdata;
  logic              re;
  logic [AW-1:0]     raddr;

  logic [CW-1:0]     lo_w;
  logic [CW-1:0]     hi_w;
  logic [CW-1:0]     hi_c;
  logic [CW-1:0]     leaf_w;
  logic [CW-1:0]     a0_w;
  logic [CW-1:0]     b0_w;
  logic              qry_empty;
  logic [AW-1:0]     leaf;
  logic [AW-1:0]     parent;
  rmst_val_t         level_min;
  rmst_val_t         acc_min;
  logic [BW-1:0]     a_inc;
  logic [BW-1:0]     b_dec;

  // Request decoding, done at a width that holds both index and tree bounds.
  assign lo_w      = CW'(in_left_index);
  assign hi_w      = CW'(in_right_index);
  assign hi_c      = (hi_w >= CW'(SIZE)) ? CW'(SIZE - 1) : hi_w;
  assign qry_empty = (lo_w >= CW'(SIZE)) || (lo_w > hi_w);
  assign leaf_w    = lo_w + CW'(SIZE);
  assign a0_w      = lo_w + CW'(SIZE);
  assign b0_w      = hi_c + CW'(SIZE) + CW'(1);
  assign leaf      = leaf_w[AW-1:0];

  assign parent    = node_r >> 1;
  assign level_min = min_val(cur_r, rdata_r);
  assign acc_min   = min_val(best_r, rdata_r);
  assign a_inc     = qa_r + BW'(qa_r[0]);
  assign b_dec     = qb_r - BW'(qb_r[0]);

  // Status to the controller.
  assign stat.clr_done = (clr_cnt_r == AW'(DEPTH - 1));
  assign stat.in_query = (in_func == FUNC_QUERY);
  assign stat.upd_ok   = (lo_w < CW'(SIZE));
  assign stat.upd_last = (parent == AW'(1));
  assign stat.qry_more = (qa_r < qb_r);
  assign stat.out_free = !out_valid_r || out_ready;

  // Write port selection.
  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt_r;
    wdata = NEUTRAL_MIN;
    priority if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.upd_start) begin
      we    = 1'b1;
      waddr = leaf;
      wdata = in_value;
    end else if (cmd.upd_level) begin
      we    = 1'b1;
      waddr = parent;
      wdata = level_min;
    end
  end

  // Read port selection: sibling on updates, span ends on queries.
  always_comb begin
    re    = 1'b0;
    raddr = leaf ^ AW'(1);
    priority if (cmd.upd_start) begin
      re = 1'b1;
    end else if (cmd.upd_level) begin
      re    = 1'b1;
      raddr = parent ^ AW'(1);
    end else if (cmd.qry_a) begin
      re    = stat.qry_more && qa_r[0];
      raddr = qa_r[AW-1:0];
    end else if (cmd.qry_b) begin
      re    = qb_r[0];
      raddr = b_dec[AW-1:0];
    end
  end

  // Node memory with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Clearing sweep counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step && !stat.clr_done) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // Update walk: current node and its freshly written value.
  always_ff @(posedge clk) begin
    if (cmd.upd_start) begin
      node_r <= leaf;
      cur_r  <= in_value;
    end else if (cmd.upd_level) begin
      node_r <= parent;
      cur_r  <= level_min;
    end
  end

  // Query walk: span bounds, pending reads and running minimum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_r <= 1'b0;
      pb_r <= 1'b0;
    end else if (cmd.qry_start) begin
      pa_r <= 1'b0;
      pb_r <= 1'b0;
    end else if (cmd.qry_a) begin
      pa_r <= stat.qry_more && qa_r[0];
      pb_r <= 1'b0;
    end else if (cmd.qry_b) begin
      pa_r <= 1'b0;
      pb_r <= qb_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.qry_start) begin
      best_r <= NEUTRAL_MIN;
      if (qry_empty) begin
        qa_r <= '0;
        qb_r <= '0;
      end else begin
        qa_r <= a0_w[BW-1:0];
        qb_r <= b0_w[BW-1:0];
      end
    end else if (cmd.qry_a) begin
      if (pb_r) best_r <= acc_min;
      if (stat.qry_more) qa_r <= a_inc;
    end else if (cmd.qry_b) begin
      if (pa_r) best_r <= acc_min;
      qa_r <= qa_r >> 1;
      qb_r <= b_dec >> 1;
    end
  end

  // Output register: holds one minimum until its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_min_r <= best_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_minimum = out_min_r;

endmodule

`default_nettype wire

>>> rtl/range_min_segment_tree_core.sv
// Update: the leaf is written, then one tree level per cycle up to the root.
// Query: phase A and phase B alternate for each tree level walked, then the minimum
// is loaded into the output register once it is free, and the next request is taken.
// Two node reads per level on the single memory read port set the query pace.
// After reset a clearing sweep writes 2*SIZE nodes, one per cycle, before the
// first request is taken; reset is synchronous and active low.
// ----------------------------------------------------------------------------
// range_min_segment_tree_core: range minimum tree with point updates
// Binary min tree over SIZE signed leaves; updates walk to the root and
// queries walk up from both ends of the span.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module range_min_segment_tree_core
  import rmst_pkg::*;
#(
  parameter int unsigned SIZE = 1024
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rmst_in_if.sink     in_chan,
  rmst_out_if.source  out_chan
);

  rmst_cmd_t  cmd;
  rmst_stat_t stat;

  // Sequencer.
  rmst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Node store and walk registers.
  rmst_datapath #(
    .SIZE (SIZE)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_func        (in_chan.func),
    .in_left_index  (in_chan.left_index),
    .in_right_index (in_chan.right_index),
    .in_value       (in_chan.value),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_minimum    (out_chan.minimum)
  );

endmodule

`default_nettype wire

>>> bench/tb_range_min_segment_tree_core.sv
// ---------------------------------------------------------------------------
// tb_range_min_segment_tree_core: self-checking bench of the range minimum tree
// Sends point updates and range queries with random gaps on both channels and
// keeps a shadow min tree that works out each query's minimum. Every result
// transfer is checked against the oldest outstanding minimum, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_range_min_segment_tree_core;
  import rmst_pkg::*;

  localparam int unsigned TREE_SIZE    = 1024;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned PRESSURE_AT  = 300;
  localparam int unsigned PRESSURE_LEN = 600;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(TREE_SIZE - 1);

  // Extremes of the 61-bit value field, both beyond the neutral value.
  localparam rmst_val_t TOP_VALUE    = {1'b0, {(VAL_W-1){1'b1}}};
  localparam rmst_val_t BOTTOM_VALUE = {1'b1, {(VAL_W-1){1'b0}}};
  localparam rmst_val_t NEG_NEUTRAL  = -NEUTRAL_MIN;
  localparam rmst_val_t MINUS_ONE    = '1;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] left_index;
    logic [IDX_W-1:0] right_index;
    rmst_val_t        value;
  } tree_req_t;

  logic clk = 1'b0;
  logic rst_n;

  rmst_in_if  req_chan ();
  rmst_out_if res_chan ();

  range_min_segment_tree_core #(.SIZE(TREE_SIZE)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan),
    .out_chan (res_chan)
  );

  tree_req_t   pending_reqs [$];
  rmst_val_t   expected_minima [$];
  rmst_val_t   shadow_tree [1:2*TREE_SIZE-1];
  int unsigned accepted_reqs  = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  logic        req_taken      = 1'b0;

  // Free-running clock.
  always #6 clk = ~clk;

  // Shadow update: write the leaf, then refresh every ancestor up to the root.
  function automatic void shadow_write(input logic [IDX_W-1:0] pos, input rmst_val_t v);
    int unsigned node;
    if (pos >= TREE_SIZE) begin
      return;
    end
    node = TREE_SIZE + pos;
    shadow_tree[node] = v;
    node = node >> 1;
    while (node >= 1) begin
      shadow_tree[node] = (shadow_tree[2*node] < shadow_tree[2*node+1]) ?
                          shadow_tree[2*node] : shadow_tree[2*node+1];
      node = node >> 1;
    end
  endfunction

  // Minimum over lo..hi, walking up from both ends of the span.
  function automatic rmst_val_t span_minimum(input logic [IDX_W-1:0] lo,
                                             input logic [IDX_W-1:0] hi);
    rmst_val_t   best;
    int unsigned a;
    int unsigned b;
    int unsigned top;
    best = NEUTRAL_MIN;
    if (lo >= TREE_SIZE || lo > hi) begin
      return best;
    end
    top = (hi >= TREE_SIZE) ? TREE_SIZE - 1 : hi;
    a = lo + TREE_SIZE;
    b = top + TREE_SIZE + 1;
    while (a < b) begin
      if (a[0]) begin
        if (shadow_tree[a] < best) begin
          best = shadow_tree[a];
        end
        a = a + 1;
      end
      if (b[0]) begin
        b = b - 1;
        if (shadow_tree[b] < best) begin
          best = shadow_tree[b];
        end
      end
      a = a >> 1;
      b = b >> 1;
    end
    return best;
  endfunction

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end
    if (roll < 88) begin
      return $urandom_range(1, 3);
    end
    if (roll < 97) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(30, 100);
  endfunction

  // Indices favour a few hot leaves at both ends, so that leaves get overwritten.
  function automatic logic [IDX_W-1:0] random_index();
    int unsigned roll;
    roll = $urandom_range(0, 3);
    if (roll == 0) begin
      return IDX_W'($urandom_range(0, 15));
    end
    if (roll == 1) begin
      return IDX_W'($urandom_range(TREE_SIZE - 16, TREE_SIZE - 1));
    end
    return IDX_W'($urandom_range(0, TREE_SIZE - 1));
  endfunction

  // Values: mostly small so that minima compete, plus extremes and raw bit patterns.
  function automatic rmst_val_t random_value();
    int unsigned roll;
    int          near_zero;
    rmst_val_t   v;
    roll = $urandom_range(0, 19);
    if (roll == 0) begin
      v = NEUTRAL_MIN;
    end else if (roll == 1) begin
      v = NEG_NEUTRAL;
    end else if (roll == 2) begin
      v = ($urandom_range(0, 1) != 0) ? TOP_VALUE : BOTTOM_VALUE;
    end else if (roll < 7) begin
      v = rmst_val_t'({$urandom, $urandom});
    end else begin
      near_zero = int'($urandom_range(0, 2000)) - 1000;
      v = rmst_val_t'(near_zero);
    end
    return v;
  endfunction

  function automatic void queue_req(input logic func, input int unsigned lo,
                                    input int unsigned hi, input rmst_val_t v);
    tree_req_t item;
    item.func        = func;
    item.left_index  = IDX_W'(lo);
    item.right_index = IDX_W'(hi);
    item.value       = v;
    pending_reqs = {pending_reqs, item};
  endfunction

  // Request acceptance: every transfer updates the shadow tree or predicts a minimum.
  always @(posedge clk) begin
    if (rst_n && req_chan.valid && req_chan.ready) begin
      if (req_chan.func == FUNC_QUERY) begin
        expected_minima = {expected_minima,
                           span_minimum(req_chan.left_index, req_chan.right_index)};
      end else begin
        shadow_write(req_chan.left_index, req_chan.value);
      end
      accepted_reqs <= accepted_reqs + 1;
    end
    req_taken <= rst_n && req_chan.valid && req_chan.ready;
  end

  // Request driver: offers the next pending item once the last one has gone.
  int unsigned send_gap   = 0;
  logic        send_burst = 1'b0;

  always @(negedge clk) begin : drive_req
    tree_req_t nxt;
    if (!rst_n) begin
      req_chan.valid <= 1'b0;
    end else if (!req_chan.valid || req_taken) begin
      if ($urandom_range(0, 199) == 0) begin
        send_burst = !send_burst;
      end
      if (send_gap != 0) begin
        send_gap = send_gap - 1;
        req_chan.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        req_chan.valid       <= 1'b1;
        req_chan.func        <= nxt.func;
        req_chan.left_index  <= nxt.left_index;
        req_chan.right_index <= nxt.right_index;
        req_chan.value       <= nxt.value;
        send_gap = send_burst ? 0 : pick_gap();
      end else begin
        req_chan.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls, bursts of steady acceptance and one long hold-off.
  int unsigned hold_left     = 0;
  logic        pressure_done = 1'b0;
  logic        take_burst    = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      res_chan.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      res_chan.ready <= 1'b0;
    end else if (!pressure_done && accepted_reqs >= PRESSURE_AT) begin
      pressure_done = 1'b1;
      hold_left = PRESSURE_LEN - 1;
      res_chan.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 149) == 0) begin
        take_burst = !take_burst;
      end
      if (take_burst || $urandom_range(0, 3) != 0) begin
        res_chan.ready <= 1'b1;
      end else begin
        res_chan.ready <= 1'b0;
        hold_left = pick_gap();
      end
    end
  end

  // Result monitor: each transfer must match the oldest outstanding minimum.
  always @(posedge clk) begin : check_result
    rmst_val_t want;
    if (rst_n && res_chan.valid && res_chan.ready) begin
      if (expected_minima.size() == 0) begin
        $error("unexpected result: minimum %0d with no query outstanding",
               res_chan.minimum);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = expected_minima.pop_front();
        if (res_chan.minimum !== want) begin
          $error("minimum mismatch: expected %0d, actual %0d", want, res_chan.minimum);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : run_bench
    int unsigned k;
    int unsigned roll;
    int unsigned lo;
    int unsigned hi;

    rst_n = 1'b0;
    req_chan.valid       = 1'b0;
    req_chan.func        = FUNC_UPDATE;
    req_chan.left_index  = '0;
    req_chan.right_index = '0;
    req_chan.value       = '0;
    res_chan.ready       = 1'b0;
    for (k = 1; k < 2 * TREE_SIZE; k++) begin
      shadow_tree[k] = NEUTRAL_MIN;
    end

    // Directed part: empty tree, field extremes, empty spans and raised minima.
    queue_req(FUNC_QUERY,  0, TREE_SIZE - 1, '0);
    queue_req(FUNC_UPDATE, 0, 0, NEG_NEUTRAL);
    queue_req(FUNC_UPDATE, TREE_SIZE - 1, 0, TOP_VALUE);
    queue_req(FUNC_UPDATE, 512, TREE_SIZE - 1, BOTTOM_VALUE);
    queue_req(FUNC_UPDATE, 511, 0, NEUTRAL_MIN);
    queue_req(FUNC_QUERY,  0, 0, TOP_VALUE);
    queue_req(FUNC_QUERY,  TREE_SIZE - 1, TREE_SIZE - 1, '0);
    queue_req(FUNC_QUERY,  0, TREE_SIZE - 1, '0);
    queue_req(FUNC_QUERY,  1, TREE_SIZE - 2, '0);
    queue_req(FUNC_QUERY,  513, TREE_SIZE - 1, '0);
    queue_req(FUNC_QUERY,  5, 3, '0);
    queue_req(FUNC_QUERY,  TREE_SIZE - 1, 0, '0);
    queue_req(FUNC_UPDATE, 512, 0, '0);
    queue_req(FUNC_QUERY,  0, TREE_SIZE - 1, '0);
    queue_req(FUNC_UPDATE, 0, 0, MINUS_ONE);
    queue_req(FUNC_QUERY,  0, TREE_SIZE - 1, '0);
    queue_req(FUNC_QUERY,  1, TREE_SIZE - 1, '0);
    queue_req(FUNC_UPDATE, 1, 0, MINUS_ONE);
    queue_req(FUNC_QUERY,  1, 1, '0);
    queue_req(FUNC_QUERY,  511, 512, '0);
    queue_req(FUNC_UPDATE, 300, 0, BOTTOM_VALUE);
    queue_req(FUNC_QUERY,  299, 301, '0);

    // Random part: half updates, half queries over short, long and empty spans.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      lo = random_index();
      if ($urandom_range(0, 1) == 0) begin
        queue_req(FUNC_UPDATE, lo, $urandom_range(0, TREE_SIZE - 1), random_value());
      end else begin
        roll = $urandom_range(0, 9);
        if (roll < 4) begin
          hi = lo + $urandom_range(0, 15);
          if (hi > TREE_SIZE - 1) begin
            hi = LAST_INDEX;
          end
        end else if (roll < 7) begin
          hi = $urandom_range(0, TREE_SIZE - 1);
        end else if (roll == 7) begin
          hi = lo;
        end else if (roll == 8) begin
          hi = LAST_INDEX;
        end else begin
          hi = (lo == 0) ? 0 : lo - 1;
        end
        queue_req(FUNC_QUERY, lo, hi, rmst_val_t'({$urandom, $urandom}));
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Let every request go, then every result, then a short quiet spell.
    while (pending_reqs.size() != 0 || req_chan.valid) begin
      @(posedge clk);
    end
    while (expected_minima.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
